[rtl/core/bbf_pkg.sv]
`timescale 1ns / 1ps

package bbf_pkg;

	// Field widths
	localparam int HASH_W    = 64;
	localparam int FUNC_W    = 2;
	localparam int SLOT_W    = 12;
	localparam int SHIFT_W   = 4;
	localparam int WORDS_W   = 13;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd3;

	// Register indexes (paddr[2])
	localparam logic REG_SHIFT = 1'b0;
	localparam logic REG_WORDS = 1'b1;

	// Register reset values
	localparam logic [SHIFT_W-1:0] SHIFT_RST = 4'd12;
	localparam logic [WORDS_W-1:0] WORDS_RST = 13'd4096;

	// Modulo unit: quotient bits retired per cycle and division steps per item
	localparam int DIV_BITS   = 8;
	localparam int DIV_STEPS  = HASH_W / DIV_BITS;
	localparam int DIV_STEP_W = $clog2(DIV_STEPS);

	localparam logic [HASH_W-1:0] ALL_ONES = {HASH_W{1'b1}};

	// Controller to datapath
	typedef struct packed {
		logic latch;
		logic div_step;
		logic sweep;
		logic upd;
		logic pat_wr;
		logic finish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sweep_last;
		logic div_last;
	} sts_t;

endpackage

[rtl/core/blocked_bloom_filter_top.sv]
`timescale 1ns / 1ps

// Channel    Handshake                       Word
// config     psel/penable/pwrite, pready=1   paddr, pwdata, prdata
// command    start accepted when !busy       func, hash, pattern_slot, pattern_word
// result     done strobe, one cycle          op_echo, maybe_present
//
// Insert and query: while busy, the modulo unit retires 8 quotient bits per
// cycle, then one filter read and one update follow; done is registered from
// the update. Load: one pattern table write. Clear: one word written per cycle
// over the whole filter. After reset the filter is filled with busy high.
// The result port has no stall; done lasts one cycle.

module blocked_bloom_filter_top #(
	parameter int BITMAP_DEPTH       = 4096,
	parameter int PATTERN_INDEX_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bbf_pkg::APB_AW-1:0]  paddr,
	input  logic [bbf_pkg::APB_DW-1:0]  pwdata,
	output logic [bbf_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	input  logic                        start,
	output logic                        busy,
	input  logic [bbf_pkg::FUNC_W-1:0]  func,
	input  logic [bbf_pkg::HASH_W-1:0]  hash,
	input  logic [bbf_pkg::SLOT_W-1:0]  pattern_slot,
	input  logic [bbf_pkg::HASH_W-1:0]  pattern_word,
	output logic                        done,
	output logic [bbf_pkg::FUNC_W-1:0]  op_echo,
	output logic                        maybe_present
);

	logic [bbf_pkg::SHIFT_W-1:0] shift_q;
	logic [bbf_pkg::WORDS_W-1:0] words_q;
	logic                        cfg_wr;
	bbf_pkg::cmd_t               cmd;
	bbf_pkg::sts_t               sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= bbf_pkg::SHIFT_RST;
			words_q <= bbf_pkg::WORDS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				bbf_pkg::REG_SHIFT: shift_q <= pwdata[bbf_pkg::SHIFT_W-1:0];
				bbf_pkg::REG_WORDS: words_q <= pwdata[bbf_pkg::WORDS_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read back
	always_comb begin
		unique case (paddr[2])
			bbf_pkg::REG_SHIFT: prdata = bbf_pkg::APB_DW'(shift_q);
			bbf_pkg::REG_WORDS: prdata = bbf_pkg::APB_DW'(words_q);
			default:            prdata = '0;
		endcase
	end

	bbf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	bbf_dpath #(
		.BITMAP_DEPTH       (BITMAP_DEPTH),
		.PATTERN_INDEX_BITS (PATTERN_INDEX_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.hash          (hash),
		.pattern_slot  (pattern_slot),
		.pattern_word  (pattern_word),
		.shift_q       (shift_q),
		.words_q       (words_q),
		.done          (done),
		.op_echo       (op_echo),
		.maybe_present (maybe_present)
	);

`ifndef SYNTH
	// An accepted word keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// One result per word: no back-to-back strobes
	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	// Only a query can report a hit
	a_maybe_query: assert property (@(posedge clk) disable iff (!arst_n)
		done && (op_echo != bbf_pkg::FUNC_QUERY) |-> !maybe_present)
		else $error("maybe_present set on a non-query result");

	// A result follows only a cycle in which the block was busy
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a word in flight");
`endif

endmodule

[rtl/core/bbf_ram.sv]
`timescale 1ns / 1ps

module bbf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/bbf_ctrl.sv]
`timescale 1ns / 1ps

module bbf_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bbf_pkg::FUNC_W-1:0] func,
	input  bbf_pkg::sts_t              sts,
	output bbf_pkg::cmd_t              cmd,
	output logic                       busy
);

	typedef enum logic [6:0] {
		ST_INIT  = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_DIV   = 7'b0000100,
		ST_RD    = 7'b0001000,
		ST_UPD   = 7'b0010000,
		ST_LOAD  = 7'b0100000,
		ST_CLEAR = 7'b1000000
	} state_t;

	state_t state_q, state_nx;

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (sts.sweep_last) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					unique case (func) inside
						bbf_pkg::FUNC_INSERT, bbf_pkg::FUNC_QUERY: state_nx = ST_DIV;
						bbf_pkg::FUNC_CLEAR: state_nx = ST_CLEAR;
						default: state_nx = ST_LOAD;
					endcase
				end
			end
			ST_DIV: begin
				if (sts.div_last) state_nx = ST_RD;
			end
			ST_RD:   state_nx = ST_UPD;
			ST_UPD:  state_nx = ST_IDLE;
			ST_LOAD: state_nx = ST_IDLE;
			ST_CLEAR: begin
				if (sts.sweep_last) state_nx = ST_IDLE;
			end
			default: state_nx = ST_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_nx;
		end
	end

	// Decode commands from state
	always_comb begin
		cmd          = '0;
		cmd.latch    = (state_q == ST_IDLE) && start;
		cmd.div_step = (state_q == ST_DIV);
		cmd.sweep    = (state_q == ST_INIT) || (state_q == ST_CLEAR);
		cmd.upd      = (state_q == ST_UPD);
		cmd.pat_wr   = (state_q == ST_LOAD);
		cmd.finish   = (state_q == ST_UPD) || (state_q == ST_LOAD) ||
			((state_q == ST_CLEAR) && sts.sweep_last);
	end

	assign busy = (state_q != ST_IDLE);

endmodule

[rtl/core/bbf_dpath.sv]
`timescale 1ns / 1ps

module bbf_dpath #(
	parameter int BITMAP_DEPTH       = 4096,
	parameter int PATTERN_INDEX_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bbf_pkg::cmd_t               cmd,
	output bbf_pkg::sts_t               sts,
	input  logic [bbf_pkg::FUNC_W-1:0]  func,
	input  logic [bbf_pkg::HASH_W-1:0]  hash,
	input  logic [bbf_pkg::SLOT_W-1:0]  pattern_slot,
	input  logic [bbf_pkg::HASH_W-1:0]  pattern_word,
	input  logic [bbf_pkg::SHIFT_W-1:0] shift_q,
	input  logic [bbf_pkg::WORDS_W-1:0] words_q,
	output logic                        done,
	output logic [bbf_pkg::FUNC_W-1:0]  op_echo,
	output logic                        maybe_present
);

	localparam int BMP_AW    = (BITMAP_DEPTH > 1) ? $clog2(BITMAP_DEPTH) : 1;
	localparam int PAT_DEPTH = 1 << PATTERN_INDEX_BITS;
	localparam int PIB       = PATTERN_INDEX_BITS;

	logic [bbf_pkg::SHIFT_W-1:0]    eff_shift;
	logic [bbf_pkg::WORDS_W-1:0]    eff_words;
	logic [PIB-1:0]                 pmask;

	logic [bbf_pkg::FUNC_W-1:0]     func_q;
	logic [bbf_pkg::SLOT_W-1:0]     slot_q;
	logic [bbf_pkg::HASH_W-1:0]     pword_q;
	logic [bbf_pkg::HASH_W-1:0]     dividend_q;
	logic [bbf_pkg::WORDS_W-1:0]    divisor_q;
	logic [bbf_pkg::WORDS_W-1:0]    rem_q;
	logic [bbf_pkg::WORDS_W-1:0]    rem_nx;
	logic [bbf_pkg::WORDS_W:0]      trial;
	logic [bbf_pkg::DIV_STEP_W-1:0] step_q;
	logic [PIB-1:0]                 pidx_q;
	logic [BMP_AW-1:0]              sweep_q;

	logic                           bmp_we;
	logic [BMP_AW-1:0]              bmp_waddr;
	logic [bbf_pkg::HASH_W-1:0]     bmp_wdata;
	logic [bbf_pkg::HASH_W-1:0]     bmp_rdata;
	logic [bbf_pkg::HASH_W-1:0]     pat_rdata;
	logic                           maybe_nx;

	logic                           done_q;
	logic [bbf_pkg::FUNC_W-1:0]     op_q;
	logic                           maybe_q;

	// Clamp register values to what the storage supports
	always_comb begin
		eff_shift = shift_q;
		if (int'(shift_q) > PATTERN_INDEX_BITS) eff_shift = bbf_pkg::SHIFT_W'(PATTERN_INDEX_BITS);
		eff_words = words_q;
		if (words_q == '0) eff_words = bbf_pkg::WORDS_W'(1);
		if (int'(words_q) > BITMAP_DEPTH) eff_words = bbf_pkg::WORDS_W'(BITMAP_DEPTH);
	end

	assign pmask = ~({PIB{1'b1}} << eff_shift);

	// Retire DIV_BITS quotient bits per cycle, keep only the remainder
	always_comb begin
		rem_nx = rem_q;
		trial  = '0;
		for (int i = 0; i < bbf_pkg::DIV_BITS; i++) begin
			trial = {rem_nx, dividend_q[bbf_pkg::HASH_W-1-i]};
			if (trial >= {1'b0, divisor_q}) trial = trial - {1'b0, divisor_q};
			rem_nx = trial[bbf_pkg::WORDS_W-1:0];
		end
	end

	// Capture the word and run the modulo unit
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q     <= func;
			slot_q     <= pattern_slot;
			pword_q    <= pattern_word;
			dividend_q <= hash >> eff_shift;
			divisor_q  <= eff_words;
			pidx_q     <= hash[PIB-1:0] & pmask;
		end else if (cmd.div_step) begin
			dividend_q <= dividend_q << bbf_pkg::DIV_BITS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.latch) begin
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= rem_nx;
			step_q <= step_q + 1'b1;
		end
	end

	// Sweep address for reset fill and clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep) begin
			if (sts.sweep_last) sweep_q <= '0;
			else sweep_q <= sweep_q + 1'b1;
		end
	end

	assign sts.sweep_last = (sweep_q == BMP_AW'(BITMAP_DEPTH - 1));
	assign sts.div_last   = (step_q == bbf_pkg::DIV_STEP_W'(bbf_pkg::DIV_STEPS - 1));

	// Select the filter write (fill word or cleared pattern bits) and the query answer
	always_comb begin
		bmp_we    = cmd.sweep || (cmd.upd && (func_q == bbf_pkg::FUNC_INSERT));
		bmp_waddr = cmd.sweep ? sweep_q : BMP_AW'(rem_q);
		bmp_wdata = cmd.sweep ? bbf_pkg::ALL_ONES : (bmp_rdata & ~pat_rdata);
		maybe_nx  = cmd.upd && (func_q == bbf_pkg::FUNC_QUERY) &&
			((bmp_rdata & pat_rdata) == '0);
	end

	bbf_ram #(
		.WIDTH (bbf_pkg::HASH_W),
		.DEPTH (BITMAP_DEPTH),
		.AW    (BMP_AW)
	) u_bitmap (
		.clk   (clk),
		.we    (bmp_we),
		.waddr (bmp_waddr),
		.wdata (bmp_wdata),
		.raddr (BMP_AW'(rem_q)),
		.rdata (bmp_rdata)
	);

	bbf_ram #(
		.WIDTH (bbf_pkg::HASH_W),
		.DEPTH (PAT_DEPTH),
		.AW    (PIB)
	) u_patterns (
		.clk   (clk),
		.we    (cmd.pat_wr),
		.waddr (PIB'(slot_q)),
		.wdata (pword_q),
		.raddr (pidx_q),
		.rdata (pat_rdata)
	);

	// Result word, shown for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			op_q    <= func_q;
			maybe_q <= maybe_nx;
		end
	end

	assign done          = done_q;
	assign op_echo       = op_q;
	assign maybe_present = maybe_q;

endmodule

[sim/bbf_checker.sv]
`timescale 1ns / 1ps

module bbf_checker
	import bbf_pkg::*;
#(
	parameter int BITMAP_DEPTH       = 4096,
	parameter int PATTERN_INDEX_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	input  logic                start,
	input  logic                busy,
	input  logic [FUNC_W-1:0]   func,
	input  logic [HASH_W-1:0]   hash,
	input  logic [SLOT_W-1:0]   pattern_slot,
	input  logic [HASH_W-1:0]   pattern_word,
	input  logic                done,
	input  logic [FUNC_W-1:0]   op_echo,
	input  logic                maybe_present,
	output int                  fail_count,
	output int                  pending
);

	localparam int PAT_DEPTH = 1 << PATTERN_INDEX_BITS;

	typedef struct packed {
		logic [FUNC_W-1:0] op;
		logic              maybe;
	} answer_t;

	// Shadow copy of the filter, the pattern table and the registers
	logic [HASH_W-1:0]  filter_mem  [BITMAP_DEPTH];
	logic [HASH_W-1:0]  pattern_mem [PAT_DEPTH];
	logic [SHIFT_W-1:0] shift_q;
	logic [WORDS_W-1:0] words_q;
	answer_t            answer_q [$];
	int                 errs = 0;

	// Clamp the shift to the table index width
	function automatic int unsigned live_shift();
		if (shift_q > PATTERN_INDEX_BITS)
			return PATTERN_INDEX_BITS;
		return shift_q;
	endfunction

	// Clamp the word count into 1..BITMAP_DEPTH
	function automatic int unsigned live_words();
		if (words_q == '0)
			return 1;
		if (words_q > BITMAP_DEPTH)
			return BITMAP_DEPTH;
		return words_q;
	endfunction

	// Apply one command word to the shadow state and return its answer
	function automatic answer_t apply_command(input logic [FUNC_W-1:0] f,
			input logic [HASH_W-1:0] h, input logic [SLOT_W-1:0] s,
			input logic [HASH_W-1:0] w);
		answer_t           a;
		int unsigned       sh;
		logic [HASH_W-1:0] modulus;
		logic [HASH_W-1:0] row;
		logic [HASH_W-1:0] pat;
		a.op    = f;
		a.maybe = 1'b0;
		sh      = live_shift();
		modulus = live_words();
		row     = (h >> sh) % modulus;
		pat     = pattern_mem[h & ((64'd1 << sh) - 64'd1)];
		case (f)
			FUNC_INSERT: filter_mem[row] &= ~pat;
			FUNC_QUERY:  a.maybe = ((filter_mem[row] & pat) == '0);
			FUNC_CLEAR:  foreach (filter_mem[i]) filter_mem[i] = ALL_ONES;
			FUNC_LOAD:   pattern_mem[s % PAT_DEPTH] = w;
		endcase
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		answer_t want;
		if (!arst_n) begin
			foreach (filter_mem[i]) filter_mem[i] = ALL_ONES;
			shift_q = SHIFT_RST;
			words_q = WORDS_RST;
			answer_q.delete();
		end else begin
			// compare the result word against the oldest prediction
			if (done) begin
				if (answer_q.size() == 0) begin
					$error("result word with nothing pending: op_echo %0d", op_echo);
					errs++;
				end else begin
					want = answer_q.pop_front();
					if (op_echo !== want.op) begin
						$error("op_echo: expected %0d, actual %0d", want.op, op_echo);
						errs++;
					end
					if (maybe_present !== want.maybe) begin
						$error("maybe_present: expected %0d, actual %0d",
							want.maybe, maybe_present);
						errs++;
					end
				end
			end
			// track register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_SHIFT)
					shift_q = pwdata[SHIFT_W-1:0];
				else
					words_q = pwdata[WORDS_W-1:0];
			end
			// predict each accepted command word
			if (start && !busy)
				answer_q.push_back(apply_command(func, hash, pattern_slot, pattern_word));
		end
		fail_count <= errs;
		pending    <= answer_q.size();
	end

endmodule

[sim/blocked_bloom_filter_top_tb.sv]
`timescale 1ns / 1ps

module blocked_bloom_filter_top_tb;
	import bbf_pkg::*;

	localparam int BITMAP_DEPTH       = 4096;
	localparam int PATTERN_INDEX_BITS = 12;
	localparam int PAT_DEPTH          = 1 << PATTERN_INDEX_BITS;
	localparam int PHASES             = 8;
	localparam int ITEMS_PER_PHASE    = 130;
	localparam int IDLE_LIMIT         = 20000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              start;
	logic              busy;
	logic [FUNC_W-1:0] func;
	logic [HASH_W-1:0] hash;
	logic [SLOT_W-1:0] pattern_slot;
	logic [HASH_W-1:0] pattern_word;
	logic              done;
	logic [FUNC_W-1:0] op_echo;
	logic              maybe_present;
	int                fail_count;
	int                pending;

	// Stimulus bookkeeping: which pattern entries hold data, recent keys
	bit                loaded_slot [PAT_DEPTH];
	int                loaded_list [$];
	logic [HASH_W-1:0] key_hist [$];
	int                key_bits;
	int                burst_left;
	int                idle_cycles;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	blocked_bloom_filter_top #(
		.BITMAP_DEPTH       (BITMAP_DEPTH),
		.PATTERN_INDEX_BITS (PATTERN_INDEX_BITS)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.hash          (hash),
		.pattern_slot  (pattern_slot),
		.pattern_word  (pattern_word),
		.done          (done),
		.op_echo       (op_echo),
		.maybe_present (maybe_present)
	);

	bbf_checker #(
		.BITMAP_DEPTH       (BITMAP_DEPTH),
		.PATTERN_INDEX_BITS (PATTERN_INDEX_BITS)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.hash          (hash),
		.pattern_slot  (pattern_slot),
		.pattern_word  (pattern_word),
		.done          (done),
		.op_echo       (op_echo),
		.maybe_present (maybe_present),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$error("no command or result word for %0d cycles", IDLE_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [HASH_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly sparse patterns, as a Bloom filter uses them, plus the extremes
	function automatic logic [HASH_W-1:0] make_pattern();
		logic [HASH_W-1:0] p;
		int                bits;
		p = '0;
		case ($urandom_range(0, 9))
			0:       p = '0;
			1:       p = '1;
			2, 3:    p = rand64();
			default: begin
				bits = $urandom_range(1, 8);
				repeat (bits) p[$urandom_range(0, 63)] = 1'b1;
			end
		endcase
		return p;
	endfunction

	// Build a key whose pattern index points at a loaded entry
	function automatic logic [HASH_W-1:0] fresh_key();
		logic [HASH_W-1:0] mask;
		int unsigned       slot;
		mask = (64'd1 << key_bits) - 64'd1;
		slot = 0;
		for (int tries = 0; tries < 8; tries++) begin
			slot = loaded_list[$urandom_range(0, loaded_list.size() - 1)] & mask;
			if (loaded_slot[slot])
				break;
		end
		if (!loaded_slot[slot])
			slot = 0;
		return (rand64() << key_bits) | slot;
	endfunction

	// Reuse an earlier inserted key when its index is still legal
	function automatic logic [HASH_W-1:0] old_key();
		logic [HASH_W-1:0] k;
		if (key_hist.size() == 0)
			return fresh_key();
		k = key_hist[$urandom_range(0, key_hist.size() - 1)];
		if (!loaded_slot[k & ((64'd1 << key_bits) - 64'd1)])
			return fresh_key();
		return k;
	endfunction

	// Drive one command word, hold it until accepted, then pace the burst
	task automatic send(input logic [FUNC_W-1:0] f, input logic [HASH_W-1:0] h,
			input logic [SLOT_W-1:0] s, input logic [HASH_W-1:0] w);
		int gap;
		start        <= 1'b1;
		func         <= f;
		hash         <= h;
		pattern_slot <= s;
		pattern_word <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (f == FUNC_LOAD && !loaded_slot[s]) begin
			loaded_slot[s] = 1'b1;
			loaded_list.push_back(s);
		end
		if (f == FUNC_INSERT) begin
			key_hist.push_back(h);
			if (key_hist.size() > 64)
				void'(key_hist.pop_front());
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			gap = $urandom_range(1, 15);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(0, 30);
		end
	endtask

	// Register write: setup phase, then access phase, then the bus returns to idle
	task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Drain all outstanding words, then set both registers
	task automatic set_config(input logic [SHIFT_W-1:0] sh, input logic [WORDS_W-1:0] nw);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		reg_write({REG_SHIFT, 2'b00}, APB_DW'(sh));
		reg_write({REG_WORDS, 2'b00}, APB_DW'(nw));
		key_bits = (sh > PATTERN_INDEX_BITS) ? PATTERN_INDEX_BITS : sh;
	endtask

	initial begin
		logic [SHIFT_W-1:0] shift_plan [PHASES];
		logic [WORDS_W-1:0] words_plan [PHASES];
		int                 sel;

		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		start        = 1'b0;
		func         = FUNC_INSERT;
		hash         = '0;
		pattern_slot = '0;
		pattern_word = '0;
		idle_cycles  = 0;
		burst_left   = 0;
		key_bits     = PATTERN_INDEX_BITS;

		// Register settings per phase: defaults, extremes, odd sizes, one random
		shift_plan = '{4'd12, 4'd0, 4'd15, 4'd4,  4'd12,    4'd13,    4'd1, 4'd0};
		words_plan = '{13'd4096, 13'd1, 13'd0, 13'd37, 13'd8191, 13'd4095, 13'd2, 13'd0};
		shift_plan[PHASES-1] = $urandom_range(0, 15);
		words_plan[PHASES-1] = $urandom_range(0, 8191);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// wait out the fill after reset
		@(posedge clk);
		while (busy) @(posedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			set_config(shift_plan[ph], words_plan[ph]);

			if (ph == 0) begin
				// Directed: pattern extremes, index extremes, wraparound, clear
				send(FUNC_LOAD,   rand64(), 12'd0,   64'h1);
				send(FUNC_LOAD,   rand64(), 12'hFFF, '1);
				send(FUNC_LOAD,   rand64(), 12'd1,   '0);
				send(FUNC_LOAD,   rand64(), 12'd2,   64'h8000_0000_0000_0001);
				send(FUNC_QUERY,  '0, '1, rand64());
				send(FUNC_INSERT, '0, '0, rand64());
				send(FUNC_QUERY,  '0, '0, rand64());
				send(FUNC_INSERT, '1, '1, '1);
				send(FUNC_QUERY,  '1, '0, '0);
				send(FUNC_QUERY,  {52'hF_FFFF_FFFF_FFFF, 12'd0}, '0, '0);
				send(FUNC_QUERY,  {52'd4096, 12'd1}, rand64(), rand64());
				send(FUNC_INSERT, {52'd5, 12'd2}, '0, '0);
				send(FUNC_QUERY,  {52'd4101, 12'd2}, '0, '0);
				send(FUNC_QUERY,  {52'd5, 12'd0}, '0, '0);
				send(FUNC_CLEAR,  rand64(), rand64(), rand64());
				send(FUNC_QUERY,  '1, '0, '0);
				send(FUNC_QUERY,  '0, '0, '0);
			end

			// Random: mostly insert/query on loaded patterns, some loads, rare clears
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < 12)
					send(FUNC_LOAD, rand64(),
						$urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 4095),
						make_pattern());
				else if (sel < 50)
					send(FUNC_INSERT, ($urandom_range(0, 4) == 0) ? old_key() : fresh_key(),
						rand64(), rand64());
				else if (sel < 98)
					send(FUNC_QUERY, $urandom_range(0, 1) ? old_key() : fresh_key(),
						rand64(), rand64());
				else
					send(FUNC_CLEAR, rand64(), rand64(), rand64());
			end
		end

		// Drain, then allow the block's latency for any stray result word
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		if (pending != 0)
			$error("%0d result words never arrived", pending);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/bbf_pkg.sv
rtl/core/bbf_ram.sv
rtl/core/bbf_ctrl.sv
rtl/core/bbf_dpath.sv
rtl/core/blocked_bloom_filter_top.sv
sim/bbf_checker.sv
sim/blocked_bloom_filter_top_tb.sv
